// ===== hdl/kps_pkg.sv =====
package kps_pkg;

  localparam int MAX_N       = 16;
  localparam int VALUE_WIDTH = 16;
  localparam int IDX_W       = $clog2(MAX_N);
  localparam int CNT_W       = $clog2(MAX_N + 1);
  localparam int CHILD_W     = IDX_W + 2;
  localparam int SUM_W       = VALUE_WIDTH + 1;
  localparam int KEY_W       = VALUE_WIDTH + 2;
  localparam int RANK_W      = 6;

  // larger than any pair sum; marks a row with no columns left
  localparam logic [KEY_W-1:0] KEY_EXHAUSTED = {1'b0, {(KEY_W-1){1'b1}}};

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [IDX_W-1:0] row;
    logic [CNT_W-1:0] col;
  } heap_ent_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INIT_RD,
    ST_INIT_WR,
    ST_SIFT_LD,
    ST_SIFT_RD,
    ST_SIFT_CH,
    ST_SIFT_CMP,
    ST_EMIT_RD,
    ST_EMIT_A,
    ST_EMIT_B
  } kps_state_e;

  function automatic logic [KEY_W-1:0] pair_key(input logic [VALUE_WIDTH-1:0] a,
                                                input logic [VALUE_WIDTH-1:0] b);
    return {{2{a[VALUE_WIDTH-1]}}, a} + {{2{b[VALUE_WIDTH-1]}}, b};
  endfunction

  function automatic logic key_lt(input logic [KEY_W-1:0] x, input logic [KEY_W-1:0] y);
    return $signed(x) < $signed(y);
  endfunction

endpackage

// ===== hdl/kps_heap_mem.sv =====
module kps_heap_mem import kps_pkg::*; (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [IDX_W-1:0] waddr_i,
  input  heap_ent_t        wdata_i,
  input  logic [IDX_W-1:0] raddr0_i,
  input  logic [IDX_W-1:0] raddr1_i,
  output heap_ent_t        rdata0_o,
  output heap_ent_t        rdata1_o
);

  heap_ent_t mem [MAX_N];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata0_o <= mem[raddr0_i];
    rdata1_o <= mem[raddr1_i];
  end

endmodule

// ===== hdl/k_smallest_pair_sums_top.sv =====
// Loads one (a, b) pair per cycle while busy_o is low; pairs past MAX_N are
// dropped. An item with last_pair_i set raises busy_o and the block then
// emits n sums (n = pairs held) in ascending order, one per strobe_o pulse;
// strobe_o cannot be held off, so sample every pulse. Build writes each
// row's first sum into the heap; heapify and each result are paced by
// the sift loop through the heap RAM (two read ports, one write port).
// busy_o drops with the final strobe.
module k_smallest_pair_sums_top import kps_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  output logic                   busy_o,
  input  logic [VALUE_WIDTH-1:0] a_value_i,
  input  logic [VALUE_WIDTH-1:0] b_value_i,
  input  logic                   last_pair_i,
  output logic                   strobe_o,
  output logic [SUM_W-1:0]       sum_o,
  output logic [RANK_W-1:0]      rank_o,
  output logic                   last_result_o
);

  kps_state_e       state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] n_q, n_d;
  logic [CNT_W-1:0] k_q, k_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic [IDX_W-1:0] pos_q, pos_d;
  logic             build_q, build_d;
  heap_ent_t        carry_q, carry_d;

  logic               strobe_d, last_d;
  logic [SUM_W-1:0]   sum_d;
  logic [RANK_W-1:0]  rank_d;

  logic [VALUE_WIDTH-1:0] a_mem [MAX_N];
  logic [VALUE_WIDTH-1:0] b_mem [MAX_N];
  logic [VALUE_WIDTH-1:0] a_rd_q, b_rd_q;
  logic [IDX_W-1:0]       a_raddr, b_raddr;
  logic                   ab_we;

  logic             h_we;
  logic [IDX_W-1:0] h_waddr, h_raddr0;
  heap_ent_t        h_wdata, h_rd0, h_rd1;

  logic               accept;
  logic [CHILD_W-1:0] left_w, right_w, n_ext;
  logic               left_ok, right_ok, take_right, sift_stop;
  heap_ent_t          best, carry_now;
  logic [IDX_W-1:0]   best_idx;
  logic [CNT_W-1:0]   colp;

  assign busy_o = (state_q != ST_IDLE);
  assign accept = start_i && !busy_o;

  assign left_w   = {1'b0, pos_q, 1'b1};
  assign right_w  = left_w + CHILD_W'(1);
  assign n_ext    = CHILD_W'(n_q);
  assign left_ok  = left_w < n_ext;
  assign right_ok = right_w < n_ext;

  assign take_right = right_ok && key_lt(h_rd1.key, h_rd0.key);
  assign best       = take_right ? h_rd1 : h_rd0;
  assign best_idx   = take_right ? right_w[IDX_W-1:0] : left_w[IDX_W-1:0];
  assign sift_stop  = !key_lt(best.key, carry_q.key);
  assign carry_now  = (state_q == ST_SIFT_RD) ? h_rd0 : carry_q;
  assign colp       = h_rd0.col + CNT_W'(1);

  kps_heap_mem u_heap (
    .clk_i    (clk_i),
    .we_i     (h_we),
    .waddr_i  (h_waddr),
    .wdata_i  (h_wdata),
    .raddr0_i (h_raddr0),
    .raddr1_i (right_w[IDX_W-1:0]),
    .rdata0_o (h_rd0),
    .rdata1_o (h_rd1)
  );

  assign ab_we = accept && (count_q < CNT_W'(MAX_N));

  always_ff @(posedge clk_i) begin
    if (ab_we) begin
      a_mem[count_q[IDX_W-1:0]] <= a_value_i;
      b_mem[count_q[IDX_W-1:0]] <= b_value_i;
    end
    a_rd_q <= a_mem[a_raddr];
    b_rd_q <= b_mem[b_raddr];
  end

  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    n_d      = n_q;
    k_d      = k_q;
    idx_d    = idx_q;
    pos_d    = pos_q;
    build_d  = build_q;
    carry_d  = carry_q;
    a_raddr  = idx_q;
    b_raddr  = '0;
    h_we     = 1'b0;
    h_waddr  = pos_q;
    h_wdata  = carry_now;
    h_raddr0 = pos_q;
    strobe_d = 1'b0;
    sum_d    = h_rd0.key[SUM_W-1:0];
    rank_d   = RANK_W'(k_q);
    last_d   = (k_q == n_q - CNT_W'(1));

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (ab_we) begin
            count_d = count_q + CNT_W'(1);
          end
          if (last_pair_i) begin
            n_d     = count_d;
            idx_d   = '0;
            state_d = ST_INIT_RD;
          end
        end
      end
      ST_INIT_RD: begin
        state_d = ST_INIT_WR;
      end
      ST_INIT_WR: begin
        h_we    = 1'b1;
        h_waddr = idx_q;
        h_wdata = '{key: pair_key(a_rd_q, b_rd_q), row: idx_q, col: '0};
        if (CNT_W'(idx_q) == n_q - CNT_W'(1)) begin
          if (n_q < CNT_W'(2)) begin
            k_d     = '0;
            build_d = 1'b0;
            state_d = ST_EMIT_RD;
          end else begin
            idx_d   = IDX_W'((n_q >> 1) - CNT_W'(1));
            pos_d   = IDX_W'((n_q >> 1) - CNT_W'(1));
            build_d = 1'b1;
            state_d = ST_SIFT_LD;
          end
        end else begin
          idx_d   = idx_q + IDX_W'(1);
          state_d = ST_INIT_RD;
        end
      end
      ST_SIFT_LD: begin
        state_d = ST_SIFT_RD;
      end
      ST_SIFT_RD, ST_SIFT_CH: begin
        carry_d  = carry_now;
        h_raddr0 = left_w[IDX_W-1:0];
        if (left_ok) begin
          state_d = ST_SIFT_CMP;
        end else begin
          h_we = (state_q == ST_SIFT_CH);
          priority if (!build_q) begin
            k_d     = k_q + CNT_W'(1);
            state_d = ST_EMIT_RD;
          end else if (idx_q == '0) begin
            k_d     = '0;
            build_d = 1'b0;
            state_d = ST_EMIT_RD;
          end else begin
            idx_d   = idx_q - IDX_W'(1);
            pos_d   = idx_q - IDX_W'(1);
            state_d = ST_SIFT_LD;
          end
        end
      end
      ST_SIFT_CMP: begin
        h_we = 1'b1;
        if (sift_stop) begin
          priority if (!build_q) begin
            k_d     = k_q + CNT_W'(1);
            state_d = ST_EMIT_RD;
          end else if (idx_q == '0) begin
            k_d     = '0;
            build_d = 1'b0;
            state_d = ST_EMIT_RD;
          end else begin
            idx_d   = idx_q - IDX_W'(1);
            pos_d   = idx_q - IDX_W'(1);
            state_d = ST_SIFT_LD;
          end
        end else begin
          h_wdata = best;
          pos_d   = best_idx;
          state_d = ST_SIFT_CH;
        end
      end
      ST_EMIT_RD: begin
        h_raddr0 = '0;
        state_d  = ST_EMIT_A;
      end
      ST_EMIT_A: begin
        strobe_d = 1'b1;
        if (last_d) begin
          count_d = '0;
          state_d = ST_IDLE;
        end else begin
          carry_d = '{key: KEY_EXHAUSTED, row: h_rd0.row, col: colp};
          pos_d   = '0;
          a_raddr = h_rd0.row;
          b_raddr = colp[IDX_W-1:0];
          state_d = (colp >= n_q) ? ST_SIFT_CH : ST_EMIT_B;
        end
      end
      ST_EMIT_B: begin
        carry_d.key = pair_key(a_rd_q, b_rd_q);
        state_d     = ST_SIFT_CH;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      count_q  <= '0;
      n_q      <= '0;
      k_q      <= '0;
      idx_q    <= '0;
      pos_q    <= '0;
      build_q  <= 1'b0;
      strobe_o <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      n_q      <= n_d;
      k_q      <= k_d;
      idx_q    <= idx_d;
      pos_q    <= pos_d;
      build_q  <= build_d;
      strobe_o <= strobe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    carry_q <= carry_d;
    if (strobe_d) begin
      sum_o         <= sum_d;
      rank_o        <= rank_d;
      last_result_o <= last_d;
    end
  end

endmodule

// ===== hdl/kps_checker.sv =====
module kps_checker import kps_pkg::*; (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   start_i,
  input logic                   busy_o,
  input logic                   last_pair_i,
  input logic                   strobe_o,
  input logic [RANK_W-1:0]      rank_o,
  input logic                   last_result_o
);

  // item that closes a run starts emission
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && last_pair_i |=> busy_o)
    else $error("last item did not start emission");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && !last_pair_i |=> !busy_o && !strobe_o)
    else $error("plain item caused activity");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && !last_result_o |-> busy_o ##1 !strobe_o)
    else $error("emission ended early or strobes back to back");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_o) |-> strobe_o && last_result_o)
    else $error("busy dropped without final result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && !last_result_o |=> !$fell(busy_o) && !(strobe_o && rank_o == '0))
    else $error("rank restarted inside a run");

endmodule

bind k_smallest_pair_sums_top kps_checker u_kps_checker (.*);
